[design/xdpr_pkg.sv]
// Package for the DTD prolog role machine: token, keyword, role and state codes.
// Shared by xdpr_step and xml_dtd_prolog_role_machine_top; depends on nothing.
`default_nettype none

package xdpr_pkg;

    localparam int DEFAULT_MAX_GROUP_DEPTH = 255;

    localparam int TOKEN_W   = 5;
    localparam int KEYWORD_W = 5;
    localparam int ROLE_W    = 6;
    localparam int STATE_W   = 6;

    // Token kinds from the upstream tokenizer; codes above TK_NAME_P mean nothing here
    typedef enum logic [TOKEN_W-1:0] {
        TK_PI         = 5'd0,
        TK_COMMENT    = 5'd1,
        TK_DECL_OPEN  = 5'd2,
        TK_NAME       = 5'd3,
        TK_LITERAL    = 5'd4,
        TK_OBRACK     = 5'd5,
        TK_CBRACK     = 5'd6,
        TK_DECL_CLOSE = 5'd7,
        TK_PERCENT    = 5'd8,
        TK_PEREF      = 5'd9,
        TK_OPAREN     = 5'd10,
        TK_CPAREN     = 5'd11,
        TK_CPAREN_Q   = 5'd12,
        TK_CPAREN_A   = 5'd13,
        TK_CPAREN_P   = 5'd14,
        TK_OR         = 5'd15,
        TK_COMMA      = 5'd16,
        TK_NMTOKEN    = 5'd17,
        TK_POUND      = 5'd18,
        TK_NAME_Q     = 5'd19,
        TK_NAME_A     = 5'd20,
        TK_NAME_P     = 5'd21
    } token_t;

    // Reserved word classes
    localparam logic [KEYWORD_W-1:0] KW_DOCTYPE  = 5'd1;
    localparam logic [KEYWORD_W-1:0] KW_SYSTEM   = 5'd2;
    localparam logic [KEYWORD_W-1:0] KW_PUBLIC   = 5'd3;
    localparam logic [KEYWORD_W-1:0] KW_NDATA    = 5'd4;
    localparam logic [KEYWORD_W-1:0] KW_PCDATA   = 5'd5;
    localparam logic [KEYWORD_W-1:0] KW_IMPLIED  = 5'd6;
    localparam logic [KEYWORD_W-1:0] KW_REQUIRED = 5'd7;
    localparam logic [KEYWORD_W-1:0] KW_FIXED    = 5'd8;
    localparam logic [KEYWORD_W-1:0] KW_EMPTY    = 5'd9;
    localparam logic [KEYWORD_W-1:0] KW_ANY      = 5'd10;
    localparam logic [KEYWORD_W-1:0] KW_NOTATION = 5'd11;
    localparam logic [KEYWORD_W-1:0] KW_CDATA    = 5'd12;
    localparam logic [KEYWORD_W-1:0] KW_ENTITY   = 5'd16;
    localparam logic [KEYWORD_W-1:0] KW_NMTOKENS = 5'd19;
    localparam logic [KEYWORD_W-1:0] KW_ELEMENT  = 5'd20;
    localparam logic [KEYWORD_W-1:0] KW_ATTLIST  = 5'd21;

    // Role codes
    localparam logic [ROLE_W-1:0] ROLE_NONE          = 6'd0;
    localparam logic [ROLE_W-1:0] ROLE_ERROR         = 6'd1;
    localparam logic [ROLE_W-1:0] ROLE_DT_NAME       = 6'd2;
    localparam logic [ROLE_W-1:0] ROLE_DT_SYSID      = 6'd3;
    localparam logic [ROLE_W-1:0] ROLE_DT_PUBID      = 6'd4;
    localparam logic [ROLE_W-1:0] ROLE_DT_CLOSE      = 6'd5;
    localparam logic [ROLE_W-1:0] ROLE_GE_NAME       = 6'd6;
    localparam logic [ROLE_W-1:0] ROLE_PE_NAME       = 6'd7;
    localparam logic [ROLE_W-1:0] ROLE_ENT_VALUE     = 6'd8;
    localparam logic [ROLE_W-1:0] ROLE_ENT_SYSID     = 6'd9;
    localparam logic [ROLE_W-1:0] ROLE_ENT_PUBID     = 6'd10;
    localparam logic [ROLE_W-1:0] ROLE_ENT_NOTATION  = 6'd11;
    localparam logic [ROLE_W-1:0] ROLE_NOT_NAME      = 6'd12;
    localparam logic [ROLE_W-1:0] ROLE_NOT_SYSID     = 6'd13;
    localparam logic [ROLE_W-1:0] ROLE_NOT_PUBID     = 6'd14;
    localparam logic [ROLE_W-1:0] ROLE_ATT_NAME      = 6'd15;
    localparam logic [ROLE_W-1:0] ROLE_ATT_CDATA     = 6'd16;
    localparam logic [ROLE_W-1:0] ROLE_ATT_ENUM      = 6'd24;
    localparam logic [ROLE_W-1:0] ROLE_ATT_NOTATION  = 6'd25;
    localparam logic [ROLE_W-1:0] ROLE_ATT_ELEM      = 6'd26;
    localparam logic [ROLE_W-1:0] ROLE_DEF_IMPLIED   = 6'd27;
    localparam logic [ROLE_W-1:0] ROLE_DEF_REQUIRED  = 6'd28;
    localparam logic [ROLE_W-1:0] ROLE_DEF_LITERAL   = 6'd29;
    localparam logic [ROLE_W-1:0] ROLE_DEF_FIXED     = 6'd30;
    localparam logic [ROLE_W-1:0] ROLE_ELEM_NAME     = 6'd31;
    localparam logic [ROLE_W-1:0] ROLE_CONTENT_ANY   = 6'd32;
    localparam logic [ROLE_W-1:0] ROLE_CONTENT_EMPTY = 6'd33;
    localparam logic [ROLE_W-1:0] ROLE_CONTENT_PCDATA = 6'd34;
    localparam logic [ROLE_W-1:0] ROLE_GROUP_OPEN    = 6'd35;
    localparam logic [ROLE_W-1:0] ROLE_GROUP_CLOSE   = 6'd36;
    localparam logic [ROLE_W-1:0] ROLE_GROUP_REP     = 6'd37;
    localparam logic [ROLE_W-1:0] ROLE_GROUP_OPT     = 6'd38;
    localparam logic [ROLE_W-1:0] ROLE_GROUP_PLUS    = 6'd39;
    localparam logic [ROLE_W-1:0] ROLE_GROUP_CHOICE  = 6'd40;
    localparam logic [ROLE_W-1:0] ROLE_GROUP_SEQ     = 6'd41;
    localparam logic [ROLE_W-1:0] ROLE_CONTENT_ELEM  = 6'd42;
    localparam logic [ROLE_W-1:0] ROLE_ELEM_OPT      = 6'd43;
    localparam logic [ROLE_W-1:0] ROLE_ELEM_REP      = 6'd44;
    localparam logic [ROLE_W-1:0] ROLE_ELEM_PLUS     = 6'd45;

    typedef enum logic [STATE_W-1:0] {
        ST_PROLOG0          = 6'd0,
        ST_PROLOG1          = 6'd1,
        ST_DT_NAME          = 6'd2,
        ST_DT_AFTER_NAME    = 6'd3,
        ST_DT_PUBID         = 6'd4,
        ST_DT_SYSID         = 6'd5,
        ST_DT_AFTER_EXTID   = 6'd6,
        ST_DT_AFTER_SUBSET  = 6'd7,
        ST_INTSUB           = 6'd8,
        ST_ENT_START        = 6'd9,
        ST_ENT_PE_NAME      = 6'd10,
        ST_ENT_DEF          = 6'd11,
        ST_ENT_PUBID        = 6'd12,
        ST_ENT_SYSID        = 6'd13,
        ST_ENT_AFTER_SYSID  = 6'd14,
        ST_ENT_NDATA_NAME   = 6'd15,
        ST_NOT_NAME         = 6'd16,
        ST_NOT_EXTID        = 6'd17,
        ST_NOT_PUBID        = 6'd18,
        ST_NOT_SYSID        = 6'd19,
        ST_ATT_ELEM         = 6'd20,
        ST_ATT_NAME         = 6'd21,
        ST_ATT_TYPE         = 6'd22,
        ST_ATT_ENUM         = 6'd23,
        ST_ATT_ENUM_SEP     = 6'd24,
        ST_ATT_NOT_OPEN     = 6'd25,
        ST_ATT_NOT_VAL      = 6'd26,
        ST_ATT_NOT_SEP      = 6'd27,
        ST_ATT_DEFAULT      = 6'd28,
        ST_ATT_FIXED        = 6'd29,
        ST_ELEM_NAME        = 6'd30,
        ST_ELEM_SPEC        = 6'd31,
        ST_ELEM_FIRST       = 6'd32,
        ST_ELEM_PCDATA      = 6'd33,
        ST_ELEM_MIXED_NAME  = 6'd34,
        ST_ELEM_MIXED_SEP   = 6'd35,
        ST_ELEM_ITEM        = 6'd36,
        ST_ELEM_AFTER_ITEM  = 6'd37,
        ST_DECLCLOSE        = 6'd38,
        ST_ERROR            = 6'd39
    } state_t;

    // What the step logic hands back to the top level for one word
    typedef struct packed {
        state_t              state;
        logic [ROLE_W-1:0]   role;
        logic                depth_overflow;
    } step_res_t;

endpackage

`default_nettype wire

[design/xdpr_step.sv]
// Transition logic of the DTD prolog role machine: next state, depth and role for one word.
// Purely combinational; uses xdpr_pkg.
`default_nettype none

module xdpr_step
    import xdpr_pkg::*;
#(
    parameter int MAX_GROUP_DEPTH = DEFAULT_MAX_GROUP_DEPTH,
    parameter int DEPTH_W         = $clog2(MAX_GROUP_DEPTH + 1)
)
(
    input  state_t                state,
    input  logic [DEPTH_W-1:0]    depth,
    input  logic [TOKEN_W-1:0]    token,
    input  logic [KEYWORD_W-1:0]  kw,
    output step_res_t             res,
    output logic [DEPTH_W-1:0]    depth_next
);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_GROUP_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_TWO = DEPTH_W'(2);

    state_t                raw_next;
    logic                  err;
    logic                  is_misc;
    logic                  is_elem;
    logic                  is_close;
    logic                  at_max;
    logic [DEPTH_W-1:0]    depth_dec;
    logic [ROLE_W-1:0]     elem_role;
    logic [ROLE_W-1:0]     close_role;

    assign is_misc  = (token == TK_PI) || (token == TK_COMMENT);
    assign at_max   = (depth >= DEPTH_MAX);
    assign depth_dec = (depth != '0) ? depth - DEPTH_ONE : depth;

    always_comb
    begin
        case (token)
            TK_NAME:   elem_role = ROLE_CONTENT_ELEM;
            TK_NAME_Q: elem_role = ROLE_ELEM_OPT;
            TK_NAME_A: elem_role = ROLE_ELEM_REP;
            TK_NAME_P: elem_role = ROLE_ELEM_PLUS;
            default:   elem_role = ROLE_NONE;
        endcase
        case (token)
            TK_CPAREN:   close_role = ROLE_GROUP_CLOSE;
            TK_CPAREN_A: close_role = ROLE_GROUP_REP;
            TK_CPAREN_Q: close_role = ROLE_GROUP_OPT;
            TK_CPAREN_P: close_role = ROLE_GROUP_PLUS;
            default:     close_role = ROLE_NONE;
        endcase
    end

    assign is_elem  = (elem_role != ROLE_NONE);
    assign is_close = (close_role != ROLE_NONE);

    // Next state and syntax error
    always_comb
    begin
        raw_next = state;
        err      = 1'b0;
        case (state)
            ST_PROLOG0:
                if (is_misc) raw_next = ST_PROLOG0;
                else if (token == TK_DECL_OPEN && kw == KW_DOCTYPE) raw_next = ST_DT_NAME;
                else err = 1'b1;
            ST_PROLOG1:
                if (!is_misc) err = 1'b1;
            ST_DT_NAME:
                if (token == TK_NAME) raw_next = ST_DT_AFTER_NAME;
                else err = 1'b1;
            ST_DT_AFTER_NAME:
                if (token == TK_OBRACK) raw_next = ST_INTSUB;
                else if (token == TK_DECL_CLOSE) raw_next = ST_PROLOG1;
                else if (token == TK_NAME && kw == KW_SYSTEM) raw_next = ST_DT_SYSID;
                else if (token == TK_NAME && kw == KW_PUBLIC) raw_next = ST_DT_PUBID;
                else err = 1'b1;
            ST_DT_PUBID:
                if (token == TK_LITERAL) raw_next = ST_DT_SYSID;
                else err = 1'b1;
            ST_DT_SYSID:
                if (token == TK_LITERAL) raw_next = ST_DT_AFTER_EXTID;
                else err = 1'b1;
            ST_DT_AFTER_EXTID:
                if (token == TK_OBRACK) raw_next = ST_INTSUB;
                else if (token == TK_DECL_CLOSE) raw_next = ST_PROLOG1;
                else err = 1'b1;
            ST_DT_AFTER_SUBSET:
                if (token == TK_DECL_CLOSE) raw_next = ST_PROLOG1;
                else err = 1'b1;
            ST_INTSUB:
                if (token == TK_DECL_OPEN && kw == KW_ENTITY) raw_next = ST_ENT_START;
                else if (token == TK_DECL_OPEN && kw == KW_ELEMENT) raw_next = ST_ELEM_NAME;
                else if (token == TK_DECL_OPEN && kw == KW_ATTLIST) raw_next = ST_ATT_ELEM;
                else if (token == TK_DECL_OPEN && kw == KW_NOTATION) raw_next = ST_NOT_NAME;
                else if (is_misc || token == TK_PEREF) raw_next = ST_INTSUB;
                else if (token == TK_CBRACK) raw_next = ST_DT_AFTER_SUBSET;
                else err = 1'b1;
            ST_ENT_START:
                if (token == TK_PERCENT) raw_next = ST_ENT_PE_NAME;
                else if (token == TK_NAME) raw_next = ST_ENT_DEF;
                else err = 1'b1;
            ST_ENT_PE_NAME:
                if (token == TK_NAME) raw_next = ST_ENT_DEF;
                else err = 1'b1;
            ST_ENT_DEF:
                if (token == TK_NAME && kw == KW_SYSTEM) raw_next = ST_ENT_SYSID;
                else if (token == TK_NAME && kw == KW_PUBLIC) raw_next = ST_ENT_PUBID;
                else if (token == TK_LITERAL) raw_next = ST_ENT_SYSID;
                else err = 1'b1;
            ST_ENT_PUBID:
                if (token == TK_LITERAL) raw_next = ST_ENT_SYSID;
                else err = 1'b1;
            ST_ENT_SYSID:
                if (token == TK_LITERAL) raw_next = ST_ENT_AFTER_SYSID;
                else err = 1'b1;
            ST_ENT_AFTER_SYSID:
                if (token == TK_DECL_CLOSE) raw_next = ST_INTSUB;
                else if (token == TK_NAME && kw == KW_NDATA) raw_next = ST_ENT_NDATA_NAME;
                else err = 1'b1;
            ST_ENT_NDATA_NAME:
                if (token == TK_NAME) raw_next = ST_DECLCLOSE;
                else err = 1'b1;
            ST_NOT_NAME:
                if (token == TK_NAME) raw_next = ST_NOT_EXTID;
                else err = 1'b1;
            ST_NOT_EXTID:
                if (token == TK_NAME && kw == KW_SYSTEM) raw_next = ST_NOT_SYSID;
                else if (token == TK_NAME && kw == KW_PUBLIC) raw_next = ST_NOT_PUBID;
                else err = 1'b1;
            ST_NOT_PUBID:
                if (token == TK_LITERAL) raw_next = ST_NOT_SYSID;
                else err = 1'b1;
            ST_NOT_SYSID:
                if (token == TK_LITERAL) raw_next = ST_DECLCLOSE;
                else err = 1'b1;
            ST_ATT_ELEM:
                if (token == TK_NAME) raw_next = ST_ATT_NAME;
                else err = 1'b1;
            ST_ATT_NAME:
                if (token == TK_DECL_CLOSE) raw_next = ST_INTSUB;
                else if (token == TK_NAME) raw_next = ST_ATT_TYPE;
                else err = 1'b1;
            ST_ATT_TYPE:
                if (token == TK_NAME && kw >= KW_CDATA && kw <= KW_NMTOKENS)
                    raw_next = ST_ATT_DEFAULT;
                else if (token == TK_NAME && kw == KW_NOTATION) raw_next = ST_ATT_NOT_OPEN;
                else if (token == TK_OPAREN) raw_next = ST_ATT_ENUM;
                else err = 1'b1;
            ST_ATT_ENUM:
                if (token == TK_NMTOKEN || token == TK_NAME) raw_next = ST_ATT_ENUM_SEP;
                else err = 1'b1;
            ST_ATT_ENUM_SEP:
                if (token == TK_CPAREN) raw_next = ST_ATT_DEFAULT;
                else if (token == TK_OR) raw_next = ST_ATT_ENUM;
                else err = 1'b1;
            ST_ATT_NOT_OPEN:
                if (token == TK_OPAREN) raw_next = ST_ATT_NOT_VAL;
                else err = 1'b1;
            ST_ATT_NOT_VAL:
                if (token == TK_NAME) raw_next = ST_ATT_NOT_SEP;
                else err = 1'b1;
            ST_ATT_NOT_SEP:
                if (token == TK_CPAREN) raw_next = ST_ATT_DEFAULT;
                else if (token == TK_OR) raw_next = ST_ATT_NOT_VAL;
                else err = 1'b1;
            ST_ATT_DEFAULT:
                if (token == TK_POUND && (kw == KW_IMPLIED || kw == KW_REQUIRED))
                    raw_next = ST_ATT_NAME;
                else if (token == TK_POUND && kw == KW_FIXED) raw_next = ST_ATT_FIXED;
                else if (token == TK_LITERAL) raw_next = ST_ATT_NAME;
                else err = 1'b1;
            ST_ATT_FIXED:
                if (token == TK_LITERAL) raw_next = ST_ATT_NAME;
                else err = 1'b1;
            ST_ELEM_NAME:
                if (token == TK_NAME) raw_next = ST_ELEM_SPEC;
                else err = 1'b1;
            ST_ELEM_SPEC:
                if (token == TK_NAME && (kw == KW_EMPTY || kw == KW_ANY))
                    raw_next = ST_DECLCLOSE;
                else if (token == TK_OPAREN) raw_next = ST_ELEM_FIRST;
                else err = 1'b1;
            ST_ELEM_FIRST:
                if (token == TK_POUND && kw == KW_PCDATA) raw_next = ST_ELEM_PCDATA;
                else if (token == TK_OPAREN) raw_next = ST_ELEM_ITEM;
                else if (is_elem) raw_next = ST_ELEM_AFTER_ITEM;
                else err = 1'b1;
            ST_ELEM_PCDATA:
                if (token == TK_CPAREN || token == TK_CPAREN_A) raw_next = ST_DECLCLOSE;
                else if (token == TK_OR) raw_next = ST_ELEM_MIXED_NAME;
                else err = 1'b1;
            ST_ELEM_MIXED_NAME:
                if (token == TK_NAME) raw_next = ST_ELEM_MIXED_SEP;
                else err = 1'b1;
            ST_ELEM_MIXED_SEP:
                if (token == TK_CPAREN_A) raw_next = ST_DECLCLOSE;
                else if (token == TK_OR) raw_next = ST_ELEM_MIXED_NAME;
                else err = 1'b1;
            ST_ELEM_ITEM:
                if (token == TK_OPAREN) err = at_max;
                else if (is_elem) raw_next = ST_ELEM_AFTER_ITEM;
                else err = 1'b1;
            ST_ELEM_AFTER_ITEM:
                if (is_close)
                begin
                    if (depth_dec == '0) raw_next = ST_DECLCLOSE;
                end
                else if (token == TK_COMMA || token == TK_OR) raw_next = ST_ELEM_ITEM;
                else err = 1'b1;
            ST_DECLCLOSE:
                if (token == TK_DECL_CLOSE) raw_next = ST_INTSUB;
                else err = 1'b1;
            default:
                raw_next = ST_ERROR;
        endcase
    end

    // Role, overflow flag, group depth and the state handed back
    always_comb
    begin
        res.role       = ROLE_NONE;
        res.depth_overflow = 1'b0;
        depth_next     = depth;
        case (state)
            ST_DT_NAME:         res.role = ROLE_DT_NAME;
            ST_DT_AFTER_NAME,
            ST_DT_AFTER_EXTID,
            ST_DT_AFTER_SUBSET:
                if (token == TK_DECL_CLOSE) res.role = ROLE_DT_CLOSE;
            ST_DT_PUBID:        res.role = ROLE_DT_PUBID;
            ST_DT_SYSID:        res.role = ROLE_DT_SYSID;
            ST_ENT_START:
                if (token == TK_NAME) res.role = ROLE_GE_NAME;
            ST_ENT_PE_NAME:     res.role = ROLE_PE_NAME;
            ST_ENT_DEF:
                if (token == TK_LITERAL) res.role = ROLE_ENT_VALUE;
            ST_ENT_PUBID:       res.role = ROLE_ENT_PUBID;
            ST_ENT_SYSID:       res.role = ROLE_ENT_SYSID;
            ST_ENT_NDATA_NAME:  res.role = ROLE_ENT_NOTATION;
            ST_NOT_NAME:        res.role = ROLE_NOT_NAME;
            ST_NOT_PUBID:       res.role = ROLE_NOT_PUBID;
            ST_NOT_SYSID:       res.role = ROLE_NOT_SYSID;
            ST_ATT_ELEM:        res.role = ROLE_ATT_ELEM;
            ST_ATT_NAME:
                if (token == TK_NAME) res.role = ROLE_ATT_NAME;
            ST_ATT_TYPE:
                if (token == TK_NAME && kw >= KW_CDATA && kw <= KW_NMTOKENS)
                    res.role = ROLE_ATT_CDATA + ROLE_W'(kw - KW_CDATA);
            ST_ATT_ENUM:        res.role = ROLE_ATT_ENUM;
            ST_ATT_NOT_VAL:     res.role = ROLE_ATT_NOTATION;
            ST_ATT_DEFAULT:
                if (token == TK_POUND && kw == KW_IMPLIED) res.role = ROLE_DEF_IMPLIED;
                else if (token == TK_POUND && kw == KW_REQUIRED) res.role = ROLE_DEF_REQUIRED;
                else if (token == TK_LITERAL) res.role = ROLE_DEF_LITERAL;
            ST_ATT_FIXED:       res.role = ROLE_DEF_FIXED;
            ST_ELEM_NAME:       res.role = ROLE_ELEM_NAME;
            ST_ELEM_SPEC:
                if (token == TK_NAME && kw == KW_EMPTY) res.role = ROLE_CONTENT_EMPTY;
                else if (token == TK_NAME && kw == KW_ANY) res.role = ROLE_CONTENT_ANY;
                else if (token == TK_OPAREN) res.role = ROLE_GROUP_OPEN;
            ST_ELEM_FIRST:
                if (token == TK_POUND && kw == KW_PCDATA) res.role = ROLE_CONTENT_PCDATA;
                else if (token == TK_OPAREN)
                begin
                    res.role   = ROLE_GROUP_OPEN;
                    depth_next = DEPTH_TWO;
                end
                else if (is_elem)
                begin
                    res.role   = elem_role;
                    depth_next = DEPTH_ONE;
                end
            // a separator in mixed content answers none; only the close answers repeat
            ST_ELEM_PCDATA,
            ST_ELEM_MIXED_SEP:
                if (token != TK_OR) res.role = ROLE_GROUP_REP;
            ST_ELEM_MIXED_NAME: res.role = ROLE_CONTENT_ELEM;
            ST_ELEM_ITEM:
                if (token == TK_OPAREN)
                begin
                    if (at_max) res.depth_overflow = 1'b1;
                    else
                    begin
                        res.role   = ROLE_GROUP_OPEN;
                        depth_next = depth + DEPTH_ONE;
                    end
                end
                else res.role = elem_role;
            ST_ELEM_AFTER_ITEM:
                if (is_close)
                begin
                    res.role   = close_role;
                    depth_next = depth_dec;
                end
                else if (token == TK_COMMA) res.role = ROLE_GROUP_SEQ;
                else if (token == TK_OR) res.role = ROLE_GROUP_CHOICE;
            default:            res.role = ROLE_NONE;
        endcase
        // error overrides whatever role the state gave
        if (err) res.role = ROLE_ERROR;
        res.state = err ? ST_ERROR : raw_next;
    end

endmodule

`default_nettype wire

[design/xml_dtd_prolog_role_machine_top.sv]
// Top level of the DTD prolog role machine: input word register, state registers, result register.
// Instantiates xdpr_step; uses xdpr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one prolog token per word, given as token_kind
//   and keyword. A word is taken at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one word per input word, carrying role and
//   depth_overflow, in input order. The receiver holds out_stall high to keep a word.
//   The accepting edge loads the input register; once the result register is free or
//   being emptied, a later edge loads the result register through the transition logic,
//   and the result stands on the output ports until the receiver takes it.
//   Throughput: one word per cycle while out_stall stays low, set by the state update that
//   sits between the two registers.
//   Stall: while the result register holds an untaken word and out_stall is high, the
//   input register holds its word and in_stall rises; otherwise both advance together.
//   Reset (rst_n low, asynchronous): both registers empty, parser back at the prolog
//   start state, group depth zero. A syntax error sends the parser to an absorbing error
//   state that answers role none to every later token until the next reset.
//   MAX_GROUP_DEPTH sets the deepest content-group nesting and the depth counter width.
`default_nettype none

module xml_dtd_prolog_role_machine_top
    import xdpr_pkg::*;
#(
    parameter int MAX_GROUP_DEPTH = DEFAULT_MAX_GROUP_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TOKEN_W-1:0]    token_kind,
    input  logic [KEYWORD_W-1:0]  keyword,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ROLE_W-1:0]     role,
    output logic                  depth_overflow
);

    localparam int DEPTH_W = $clog2(MAX_GROUP_DEPTH + 1);

    // input word register
    logic                  in_valid_reg, in_valid_next;
    logic [TOKEN_W-1:0]    token_reg;
    logic [KEYWORD_W-1:0]  kw_reg;

    // parser state
    state_t                state_reg, state_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [ROLE_W-1:0]     role_reg;
    logic                  ovf_reg;

    logic                  in_fire;
    logic                  advance;
    step_res_t             step_res;

    // Advance the held word whenever the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    xdpr_step #(
        .MAX_GROUP_DEPTH (MAX_GROUP_DEPTH),
        .DEPTH_W         (DEPTH_W)
    ) u_step (
        .state      (state_reg),
        .depth      (depth_reg),
        .token      (token_reg),
        .kw         (kw_reg),
        .res        (step_res),
        .depth_next (depth_next)
    );

    assign state_next = step_res.state;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire) in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance) out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall) out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_PROLOG0;
            depth_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
                depth_reg <= depth_next;
            end
        end
    end

    // payload: capture the word on acceptance, the result on advance
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            token_reg <= token_kind;
            kw_reg    <= keyword;
        end
        if (advance)
        begin
            role_reg <= step_res.role;
            ovf_reg  <= step_res.depth_overflow;
        end
    end

    assign out_valid      = out_valid_reg;
    assign role           = role_reg;
    assign depth_overflow = ovf_reg;

    // The error state is absorbing
    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ERROR |=> state_reg == ST_ERROR)
        else $error("parser left the error state");

    // An overflow flag always comes with the error role
    a_ovf_is_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ovf_reg |-> role_reg == ROLE_ERROR)
        else $error("depth overflow without error role");

    // Depth is nonzero only inside a content group or after an error there
    a_depth_scope: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg != '0 |-> (state_reg == ST_ELEM_ITEM || state_reg == ST_ELEM_AFTER_ITEM
                             || state_reg == ST_ERROR))
        else $error("group depth nonzero outside a content group");

    // Depth never passes the configured maximum
    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_GROUP_DEPTH))
        else $error("group depth above maximum");

endmodule

`default_nettype wire
